### hw/rtl/jlh_pkg.sv
// Shared types, constants and the mix round function for the lookup2 byte hash.
// Used by jlh_final_mix, jenkins_lookup2_byte_hash and lookup2_hash_checker; depends on nothing.
`timescale 1ns / 1ps

package jlh_pkg;

    localparam logic [31:0] GOLDEN_INIT = 32'h9E3779B9;
    localparam int          BLOCK_LEN   = 12;
    localparam int          MIX_ROUNDS  = 9;
    localparam int          FIFO_DEPTH  = 16;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
    } t_abc;

    typedef struct packed {
        logic zero;
        t_abc abc;
    } t_job;

    // One line of the mix: one word updated from the other two.
    function automatic t_abc mix_round(input t_abc s, input logic [3:0] rnd);
        t_abc r;
        r = s;
        case (rnd)
            4'd0: r.a = (s.a - s.b - s.c) ^ (s.c >> 13);
            4'd1: r.b = (s.b - s.c - s.a) ^ (s.a << 8);
            4'd2: r.c = (s.c - s.a - s.b) ^ (s.b >> 13);
            4'd3: r.a = (s.a - s.b - s.c) ^ (s.c >> 12);
            4'd4: r.b = (s.b - s.c - s.a) ^ (s.a << 16);
            4'd5: r.c = (s.c - s.a - s.b) ^ (s.b >> 5);
            4'd6: r.a = (s.a - s.b - s.c) ^ (s.c >> 3);
            4'd7: r.b = (s.b - s.c - s.a) ^ (s.a << 10);
            4'd8: r.c = (s.c - s.a - s.b) ^ (s.b >> 15);
            default: r = s;
        endcase
        return r;
    endfunction

endpackage

### hw/rtl/jenkins_lookup2_byte_hash.sv
// Top level of the streaming lookup2 32-bit byte hash (initial value 0).
// Depends on jlh_pkg, jlh_final_mix and jlh_out_fifo.
`timescale 1ns / 1ps

// One message byte is taken per clock while the input does not stall. A
// full 12-byte block is added into a, b and c and mixed by an iterative
// unit that runs one mix line per cycle while the next block fills. The
// finish (length, tail bytes) enters the final mix pipeline, whose result
// word goes into the output FIFO. If the last byte arrives while a block
// mix is still running, or completes a block, the input stalls until that
// mix ends. An empty message gives 0 in order with the others. Up to
// P_FIFO_DEPTH results may be outstanding; the input stalls when that many
// wait to be taken.
module jenkins_lookup2_byte_hash #(
    parameter int P_FIFO_DEPTH = jlh_pkg::FIFO_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    input  logic        i_message_empty,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_hash_value
);

    localparam int OCW = $clog2(P_FIFO_DEPTH + 1);
    localparam int NB  = jlh_pkg::BLOCK_LEN;

    logic [31:0]    r_ma;
    logic [31:0]    r_mb;
    logic [31:0]    r_mc;
    logic [3:0]     r_fill;
    logic [31:0]    r_len;
    logic           r_busy;
    logic [3:0]     r_round;
    logic           r_pend;
    logic [OCW-1:0] r_occ;
    logic [7:0]     r_buf [NB];

    logic [31:0]    n_ma;
    logic [31:0]    n_mb;
    logic [31:0]    n_mc;
    logic [3:0]     n_fill;
    logic [31:0]    n_len;
    logic           n_busy;
    logic [3:0]     n_round;
    logic           n_pend;
    logic [OCW-1:0] n_occ;

    logic           in_acc;
    logic           out_acc;
    logic           blk_done;
    logic           fin_go;
    logic           mf_valid;
    logic [31:0]    mf_hash;
    logic [7:0]     view     [NB];
    logic [7:0]     fin_src  [NB];
    logic [7:0]     fin_byte [NB];
    logic [3:0]     fin_n;
    logic [31:0]    fin_len;
    logic [31:0]    tail_a;
    logic [31:0]    tail_b;
    logic [31:0]    tail_c;
    jlh_pkg::t_abc  mixed;
    jlh_pkg::t_job  job;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign blk_done = (r_fill == 4'(NB - 1));
    assign fin_go   = (in_acc && i_last_byte && !i_message_empty && !blk_done && !r_busy)
                   || (r_pend && !r_busy);
    assign o_in_stall = r_pend || (r_occ == OCW'(P_FIFO_DEPTH));

    always_comb begin
        for (int i = 0; i < NB; i++) begin
            view[i]    = (4'(i) == r_fill) ? i_data_byte : r_buf[i];
            fin_src[i] = r_pend ? r_buf[i] : view[i];
        end
        fin_n   = r_pend ? r_fill : r_fill + 4'd1;
        fin_len = r_pend ? r_len : r_len + 32'd1;
        for (int i = 0; i < NB; i++) begin
            fin_byte[i] = (4'(i) < fin_n) ? fin_src[i] : 8'h00;
        end
        tail_a = {fin_byte[3], fin_byte[2], fin_byte[1], fin_byte[0]};
        tail_b = {fin_byte[7], fin_byte[6], fin_byte[5], fin_byte[4]};
        tail_c = {fin_byte[10], fin_byte[9], fin_byte[8], 8'h00};
        job.zero  = in_acc && i_message_empty;
        job.abc.a = r_ma + tail_a;
        job.abc.b = r_mb + tail_b;
        job.abc.c = r_mc + fin_len + tail_c;
    end

    assign mixed = jlh_pkg::mix_round('{a: r_ma, b: r_mb, c: r_mc}, r_round);

    always_comb begin
        n_ma    = r_ma;
        n_mb    = r_mb;
        n_mc    = r_mc;
        n_fill  = r_fill;
        n_len   = r_len;
        n_busy  = r_busy;
        n_round = r_round;
        n_pend  = r_pend;
        if ((in_acc && i_message_empty) || fin_go) begin
            n_ma    = jlh_pkg::GOLDEN_INIT;
            n_mb    = jlh_pkg::GOLDEN_INIT;
            n_mc    = 32'h0;
            n_fill  = 4'd0;
            n_len   = 32'h0;
            n_busy  = 1'b0;
            n_round = 4'd0;
            n_pend  = 1'b0;
        end else begin
            if (in_acc) begin
                n_len = r_len + 32'd1;
                if (blk_done) begin
                    n_fill  = 4'd0;
                    n_ma    = r_ma + {view[3], view[2], view[1], view[0]};
                    n_mb    = r_mb + {view[7], view[6], view[5], view[4]};
                    n_mc    = r_mc + {view[11], view[10], view[9], view[8]};
                    n_busy  = 1'b1;
                    n_round = 4'd0;
                end else begin
                    n_fill = r_fill + 4'd1;
                end
                if (i_last_byte) begin
                    n_pend = 1'b1;
                end
            end
            if (r_busy) begin
                n_ma    = mixed.a;
                n_mb    = mixed.b;
                n_mc    = mixed.c;
                n_round = r_round + 4'd1;
                if (r_round == 4'(jlh_pkg::MIX_ROUNDS - 1)) begin
                    n_busy = 1'b0;
                end
            end
        end
    end

    always_comb begin
        n_occ = r_occ;
        if (in_acc && (i_last_byte || i_message_empty) && !out_acc) begin
            n_occ = r_occ + 1'b1;
        end else if (!(in_acc && (i_last_byte || i_message_empty)) && out_acc) begin
            n_occ = r_occ - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ma    <= jlh_pkg::GOLDEN_INIT;
            r_mb    <= jlh_pkg::GOLDEN_INIT;
            r_mc    <= 32'h0;
            r_fill  <= 4'd0;
            r_len   <= 32'h0;
            r_busy  <= 1'b0;
            r_round <= 4'd0;
            r_pend  <= 1'b0;
            r_occ   <= '0;
        end else begin
            r_ma    <= n_ma;
            r_mb    <= n_mb;
            r_mc    <= n_mc;
            r_fill  <= n_fill;
            r_len   <= n_len;
            r_busy  <= n_busy;
            r_round <= n_round;
            r_pend  <= n_pend;
            r_occ   <= n_occ;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && !i_message_empty) begin
            r_buf[r_fill] <= i_data_byte;
        end
    end

    jlh_final_mix u_final_mix (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (fin_go || (in_acc && i_message_empty)),
        .i_job        (job),
        .o_valid      (mf_valid),
        .o_hash_value (mf_hash)
    );

    jlh_out_fifo #(
        .P_DEPTH (P_FIFO_DEPTH)
    ) u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (mf_valid),
        .i_data  (mf_hash),
        .i_pop   (out_acc),
        .o_valid (o_out_valid),
        .o_data  (o_hash_value)
    );

    assign out_acc = o_out_valid && !i_out_stall;

`ifndef SYNTHESIS
    a_blk_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && blk_done && !i_message_empty) |-> !r_busy)
        else $error("block completed while mixer busy");

    a_pend_launch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend && !r_busy) |=> !r_pend)
        else $error("pending finish not launched");

    a_empty_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_message_empty) |=> (r_fill == 4'd0 && !r_busy && r_len == 32'h0))
        else $error("empty message did not reset state");

    a_occ_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_occ == '0) |-> !o_out_valid)
        else $error("result shown with nothing outstanding");
`endif

endmodule

### hw/rtl/jlh_final_mix.sv
// Final mix pipeline, one mix line per stage after the input register, feeding the result word.
// Depends on jlh_pkg (t_job, mix_round).
`timescale 1ns / 1ps

module jlh_final_mix (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  jlh_pkg::t_job i_job,
    output logic          o_valid,
    output logic [31:0]   o_hash_value
);

    localparam int NST = jlh_pkg::MIX_ROUNDS + 1;

    logic          r_v   [NST];
    jlh_pkg::t_job r_job [NST];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NST; k++) begin
                r_v[k] <= 1'b0;
            end
        end else begin
            r_v[0] <= i_push;
            for (int k = 1; k < NST; k++) begin
                r_v[k] <= r_v[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_job[0] <= i_job;
        for (int k = 1; k < NST; k++) begin
            r_job[k].zero <= r_job[k-1].zero;
            r_job[k].abc  <= jlh_pkg::mix_round(r_job[k-1].abc, 4'(k - 1));
        end
    end

    assign o_valid      = r_v[NST-1];
    assign o_hash_value = r_job[NST-1].zero ? 32'h0 : r_job[NST-1].abc.c;

endmodule

### hw/rtl/jlh_out_fifo.sv
// Result FIFO between the final mix pipeline and the output channel.
// Standalone; depth comes from the top level.
`timescale 1ns / 1ps

module jlh_out_fifo #(
    parameter int P_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  logic [31:0] i_data,
    input  logic        i_pop,
    output logic        o_valid,
    output logic [31:0] o_data
);

    localparam int AW = $clog2(P_DEPTH);
    localparam int CW = $clog2(P_DEPTH + 1);

    logic [31:0]   r_mem [P_DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [CW-1:0] r_cnt;
    logic [AW-1:0] n_wr;
    logic [AW-1:0] n_rd;
    logic [CW-1:0] n_cnt;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == AW'(P_DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == AW'(P_DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];

endmodule

### tb/lookup2_hash_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the lookup2 byte hash: folds accepted message bytes into its
// own hash state and checks each output word against the oldest hash due.
// Depends on jlh_pkg for the seed value and the block length.

module lookup2_hash_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    input  logic        i_message_empty,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [31:0] i_hash_value,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_hashes_checked
);

    localparam int REPORT_LIMIT = 10;

    logic [31:0] acc_a;
    logic [31:0] acc_b;
    logic [31:0] acc_c;
    logic [31:0] msg_len;
    logic [7:0]  blk [jlh_pkg::BLOCK_LEN];
    int unsigned blk_fill;
    logic [31:0] hash_expected_q [$];

    initial begin
        o_fail_count     = 0;
        o_pending        = 0;
        o_hashes_checked = 0;
    end

    task automatic scramble_abc(inout logic [31:0] a, inout logic [31:0] b,
                                inout logic [31:0] c);
        a = a - b - c;  a = a ^ (c >> 13);
        b = b - c - a;  b = b ^ (a << 8);
        c = c - a - b;  c = c ^ (b >> 13);
        a = a - b - c;  a = a ^ (c >> 12);
        b = b - c - a;  b = b ^ (a << 16);
        c = c - a - b;  c = c ^ (b >> 5);
        a = a - b - c;  a = a ^ (c >> 3);
        b = b - c - a;  b = b ^ (a << 10);
        c = c - a - b;  c = c ^ (b >> 15);
    endtask

    task automatic clear_message();
        acc_a    = jlh_pkg::GOLDEN_INIT;
        acc_b    = jlh_pkg::GOLDEN_INIT;
        acc_c    = '0;
        msg_len  = '0;
        blk_fill = 0;
    endtask

    task automatic absorb_byte(input logic [7:0] d, input logic last);
        int unsigned k;
        logic [31:0] v;
        blk[blk_fill] = d;
        blk_fill++;
        msg_len++;
        if (blk_fill == jlh_pkg::BLOCK_LEN) begin
            acc_a += {blk[3], blk[2], blk[1], blk[0]};
            acc_b += {blk[7], blk[6], blk[5], blk[4]};
            acc_c += {blk[11], blk[10], blk[9], blk[8]};
            scramble_abc(acc_a, acc_b, acc_c);
            blk_fill = 0;
        end
        if (last) begin
            acc_c += msg_len;
            for (k = 0; k < blk_fill; k++) begin
                v = {24'd0, blk[k]};
                if (k < 4) begin
                    acc_a += v << (8 * (k % 4));
                end else if (k < 8) begin
                    acc_b += v << (8 * (k % 4));
                end else begin
                    // keep the low byte of c for the length
                    acc_c += v << (8 * (k % 4 + 1));
                end
            end
            scramble_abc(acc_a, acc_b, acc_c);
            hash_expected_q.push_back(acc_c);
            clear_message();
        end
    endtask

    always @(posedge i_clk) begin : watch
        logic [31:0] want;
        if (!i_rst_n) begin
            clear_message();
            hash_expected_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (hash_expected_q.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= REPORT_LIMIT) begin
                        $display("unexpected hash word %08h at %0t", i_hash_value, $realtime);
                    end
                end else begin
                    want = hash_expected_q.pop_front();
                    o_hashes_checked++;
                    if (i_hash_value !== want) begin
                        o_fail_count++;
                        if (o_fail_count <= REPORT_LIMIT) begin
                            $display("hash mismatch at %0t: expected %08h, got %08h",
                                     $realtime, want, i_hash_value);
                        end
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_message_empty) begin
                    clear_message();
                    hash_expected_q.push_back('0);
                end else begin
                    absorb_byte(i_data_byte, i_last_byte);
                end
            end
        end
        o_pending = hash_expected_q.size();
    end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// Top of the lookup2 byte hash testbench: clock, reset, message stimulus,
// random output stalls and the verdict. Depends on jenkins_lookup2_byte_hash
// and lookup2_hash_checker.

module tb;

    localparam int ITEM_TARGET    = 950;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 40;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [7:0]  i_data_byte;
    logic        i_last_byte;
    logic        i_message_empty;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [31:0] o_hash_value;

    int fail_count;
    int pending;
    int hashes_checked;

    bit sender_quiet;
    bit drain_quiet;
    bit hold_off_req;
    int words_sent;
    int messages_sent;
    int empties_sent;
    int aborts_sent;
    int holds_done;
    int idle_cycles = 0;

    jenkins_lookup2_byte_hash dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_data_byte     (i_data_byte),
        .i_last_byte     (i_last_byte),
        .i_message_empty (i_message_empty),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_hash_value    (o_hash_value)
    );

    lookup2_hash_checker hash_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_in_stall       (o_in_stall),
        .i_data_byte      (i_data_byte),
        .i_last_byte      (i_last_byte),
        .i_message_empty  (i_message_empty),
        .i_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .i_hash_value     (o_hash_value),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_hashes_checked (hashes_checked)
    );

    initial i_clk = 1'b0;
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    task automatic send_word(input logic [7:0] d, input logic last, input logic empty);
        int gap;
        gap = sender_quiet ? 0 : $urandom_range(0, 9);
        @(negedge i_clk);
        if (gap != 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_data_byte     = d;
        i_last_byte     = last;
        i_message_empty = empty;
        i_in_valid      = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        words_sent++;
        if (empty || last) messages_sent++;
        if (empty) empties_sent++;
    endtask

    task automatic send_message(input int unsigned nbytes, input bit cut_short);
        int unsigned k;
        for (k = 0; k < nbytes; k++) begin
            send_word(8'($urandom_range(0, 255)), (k == nbytes - 1) && !cut_short, 1'b0);
        end
        if (cut_short) begin
            aborts_sent++;
            send_word(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
        end
    endtask

    initial begin : stimulus
        int k;
        int pick;
        i_rst_n         = 1'b0;
        i_in_valid      = 1'b0;
        i_data_byte     = '0;
        i_last_byte     = 1'b0;
        i_message_empty = 1'b0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        send_word(8'h00, 1'b0, 1'b1);
        send_word(8'hFF, 1'b1, 1'b1);
        send_word(8'h00, 1'b1, 1'b0);
        send_word(8'hFF, 1'b1, 1'b0);
        for (k = 0; k < 12; k++) begin
            send_word(8'hFF - k[7:0], k == 11, 1'b0);
        end
        for (k = 0; k < 3; k++) begin
            send_word(8'h10 + k[7:0], 1'b0, 1'b0);
        end
        send_word(8'h00, 1'b0, 1'b1);
        send_word(8'hA5, 1'b0, 1'b0);
        send_word(8'h5A, 1'b1, 1'b0);

        // back up the output so the input stalls
        hold_off_req = 1'b1;
        sender_quiet = 1'b1;
        for (k = 0; k < 40; k++) begin
            send_word(8'($urandom_range(0, 255)), 1'b1, $urandom_range(0, 7) == 0);
        end
        sender_quiet = 1'b0;

        while (words_sent < ITEM_TARGET) begin
            if (messages_sent % 8 == 0) begin
                sender_quiet = ($urandom_range(0, 3) == 0);
                drain_quiet  = ($urandom_range(0, 3) == 0);
            end
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                send_word(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
            end else if (pick < 14) begin
                send_message($urandom_range(1, 30), 1'b1);
            end else if (pick < 22) begin
                send_message($urandom_range(25, 60), 1'b0);
            end else begin
                send_message($urandom_range(1, 24), 1'b0);
            end
        end
        @(negedge i_clk);
        i_in_valid = 1'b0;
        drain_quiet = 1'b0;

        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Sent %0d input words in %0d messages (%0d empty, %0d cut short);",
                 words_sent, messages_sent, empties_sent, aborts_sent);
        $display("%0d hashes checked; output held off %0d time(s) for %0d cycles; %0d mismatches.",
                 hashes_checked, holds_done, HOLD_CYCLES, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin : drain
        int n;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            n = drain_quiet ? 0 : $urandom_range(0, 9);
            if (hold_off_req) begin
                n = HOLD_CYCLES;
                hold_off_req = 1'b0;
                holds_done++;
            end
            if (n != 0) begin
                i_out_stall = 1'b1;
                repeat (n) @(negedge i_clk);
            end
            i_out_stall = 1'b0;
            do @(posedge i_clk); while (!(o_out_valid && !i_out_stall));
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("no word moved for %0d cycles, %0d hashes outstanding",
                     idle_cycles, pending);
            $display("TEST FAILED");
            $finish;
        end
    end

endmodule

### jenkins_lookup2_byte_hash.f
hw/rtl/jlh_pkg.sv
hw/rtl/jlh_final_mix.sv
hw/rtl/jlh_out_fifo.sv
hw/rtl/jenkins_lookup2_byte_hash.sv
tb/lookup2_hash_checker.sv
tb/tb.sv
